FILE: hdl/hcw_pkg.sv
// Shared types and constants for the hyper Cullen-Woodall factor check unit.
`default_nettype none
package hcw_pkg;

    localparam int MODULUS_WIDTH_DEF  = 62;
    localparam int EXPONENT_WIDTH_DEF = 30;
    localparam int FACTOR_W           = 62;
    localparam int TERM_W             = 30;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [TERM_W-1:0]   base_b;
        logic [TERM_W-1:0]   exponent_n;
        logic                minus_sign;
    } in_t;

    typedef struct packed {
        logic                divides;
        logic [FACTOR_W-1:0] residue;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MM_LOAD,
        ST_MM_RUN,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic [2:0] {
        OP_RED_B,
        OP_RED_N,
        OP_SQ,
        OP_MUL,
        OP_FIN
    } mm_op_t;

    typedef struct packed {
        logic   load;
        logic   mm_start;
        logic   mm_step;
        logic   mm_wb;
        mm_op_t op;
        logic   pow_init;
        logic   pow_sel;
        logic   exp_shift;
        logic   save_r1;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic bad_in;
        logic exp_bit;
        logic pow_sel;
    } status_t;

endpackage
`default_nettype wire

FILE: hdl/hcw_datapath.sv
// Datapath: operand registers, bit-serial modular multiplier, result register.
`default_nettype none
module hcw_datapath #(
    parameter int MW = hcw_pkg::MODULUS_WIDTH_DEF,
    parameter int EW = hcw_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire hcw_pkg::cmd_t   cmd,
    output hcw_pkg::status_t     sts,
    input  wire hcw_pkg::in_t    in_data,
    output hcw_pkg::out_t        out_data
);

    localparam int YW = (MW > EW) ? MW : EW;

    logic [MW-1:0] p_reg, xb_reg, xn_reg, acc_reg, r1_reg, mm_acc_reg, mm_x_reg;
    logic [EW-1:0] b_reg, n_reg, e_reg;
    logic [YW-1:0] mm_y_reg;
    logic          minus_reg, bad_reg, pow_sel_reg;
    hcw_pkg::out_t out_reg;

    logic [MW-1:0] ld_x;
    logic [YW-1:0] ld_y;
    logic [MW:0]   dbl, dred, sum;
    logic [MW-1:0] mm_next;
    logic [MW-1:0] in_p;

    assign in_p = MW'(in_data.factor);

    always_comb
    begin
        dbl  = {mm_acc_reg, 1'b0};
        dred = (dbl >= {1'b0, p_reg}) ? dbl - {1'b0, p_reg} : dbl;
        sum  = dred + (mm_y_reg[YW-1] ? {1'b0, mm_x_reg} : '0);
        mm_next = (sum >= {1'b0, p_reg}) ? MW'(sum - {1'b0, p_reg}) : MW'(sum);
    end

    always_comb
    begin
        case (cmd.op)
            hcw_pkg::OP_RED_B:
            begin
                ld_x = MW'(1);
                ld_y = YW'(b_reg);
            end
            hcw_pkg::OP_RED_N:
            begin
                ld_x = MW'(1);
                ld_y = YW'(n_reg);
            end
            hcw_pkg::OP_SQ:
            begin
                ld_x = acc_reg;
                ld_y = YW'(acc_reg);
            end
            hcw_pkg::OP_MUL:
            begin
                ld_x = pow_sel_reg ? xn_reg : xb_reg;
                ld_y = YW'(acc_reg);
            end
            default:
            begin
                ld_x = r1_reg;
                ld_y = YW'(acc_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg     <= in_p;
            b_reg     <= EW'(in_data.base_b);
            n_reg     <= EW'(in_data.exponent_n);
            minus_reg <= in_data.minus_sign;
            bad_reg   <= sts.bad_in;
        end
        if (cmd.mm_start)
        begin
            mm_acc_reg <= '0;
            mm_x_reg   <= ld_x;
            mm_y_reg   <= ld_y;
        end
        if (cmd.mm_step)
        begin
            mm_acc_reg <= mm_next;
            mm_y_reg   <= {mm_y_reg[YW-2:0], 1'b0};
        end
        if (cmd.mm_wb)
        begin
            case (cmd.op)
                hcw_pkg::OP_RED_B: xb_reg  <= mm_next;
                hcw_pkg::OP_RED_N: xn_reg  <= mm_next;
                default:
                    if (!cmd.pow_init)
                        acc_reg <= mm_next;
            endcase
        end
        if (cmd.save_r1)
            r1_reg <= mm_next;
        if (cmd.pow_init)
        begin
            acc_reg     <= MW'(1);
            e_reg       <= cmd.pow_sel ? b_reg : n_reg;
            pow_sel_reg <= cmd.pow_sel;
        end
        else if (cmd.exp_shift)
            e_reg <= {e_reg[EW-2:0], 1'b0};
        if (cmd.out_load)
        begin
            out_reg.residue <= bad_reg ? '0 : hcw_pkg::FACTOR_W'(acc_reg);
            out_reg.divides <= !bad_reg && (minus_reg ? (acc_reg == MW'(1))
                                                      : (acc_reg == p_reg - MW'(1)));
        end
    end

    assign sts.bad_in  = (in_p < MW'(3)) || !in_p[0];
    assign sts.exp_bit = e_reg[EW-1];
    assign sts.pow_sel = pow_sel_reg;
    assign out_data    = out_reg;

endmodule
`default_nettype wire

FILE: hdl/hcw_controller.sv
// Controller: sequences reductions, two exponentiations and the final product.
`default_nettype none
module hcw_controller #(
    parameter int MW = hcw_pkg::MODULUS_WIDTH_DEF,
    parameter int EW = hcw_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire hcw_pkg::status_t sts,
    output hcw_pkg::cmd_t         cmd
);

    localparam int YW  = (MW > EW) ? MW : EW;
    localparam int CW  = $clog2(YW);
    localparam int ECW = $clog2(EW);

    hcw_pkg::state_t state_reg, state_next;
    hcw_pkg::mm_op_t op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [ECW-1:0]  ecnt_reg, ecnt_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcw_pkg::ST_IDLE;
            op_reg        <= hcw_pkg::OP_RED_B;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        ecnt_next  = ecnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            hcw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = hcw_pkg::OP_RED_B;
                    state_next = sts.bad_in ? hcw_pkg::ST_OUT_WAIT : hcw_pkg::ST_MM_LOAD;
                end
            end
            hcw_pkg::ST_MM_LOAD:
            begin
                cmd.mm_start = 1'b1;
                cnt_next     = '0;
                state_next   = hcw_pkg::ST_MM_RUN;
            end
            hcw_pkg::ST_MM_RUN:
            begin
                cmd.mm_step = 1'b1;
                cnt_next    = cnt_reg + CW'(1);
                if (cnt_reg == CW'(YW - 1))
                begin
                    cmd.mm_wb  = 1'b1;
                    state_next = hcw_pkg::ST_MM_LOAD;
                    case (op_reg)
                        hcw_pkg::OP_RED_B:
                            op_next = hcw_pkg::OP_RED_N;
                        hcw_pkg::OP_RED_N:
                        begin
                            cmd.pow_init = 1'b1;
                            cmd.pow_sel  = 1'b0;
                            ecnt_next    = '0;
                            op_next      = hcw_pkg::OP_SQ;
                        end
                        hcw_pkg::OP_SQ,
                        hcw_pkg::OP_MUL:
                        begin
                            if (op_reg == hcw_pkg::OP_SQ && sts.exp_bit)
                                op_next = hcw_pkg::OP_MUL;
                            else
                            begin
                                cmd.exp_shift = 1'b1;
                                ecnt_next     = ecnt_reg + ECW'(1);
                                op_next       = hcw_pkg::OP_SQ;
                                if (ecnt_reg == ECW'(EW - 1))
                                begin
                                    ecnt_next = '0;
                                    if (!sts.pow_sel)
                                    begin
                                        cmd.save_r1  = 1'b1;
                                        cmd.pow_init = 1'b1;
                                        cmd.pow_sel  = 1'b1;
                                    end
                                    else
                                        op_next = hcw_pkg::OP_FIN;
                                end
                            end
                        end
                        default:
                            state_next = hcw_pkg::ST_OUT_WAIT;
                    endcase
                end
            end
            hcw_pkg::ST_OUT_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = hcw_pkg::ST_IDLE;
                end
            end
            default:
                state_next = hcw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

    a_ecnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= ECW'(EW - 1))
        else $error("exponent bit counter out of range");

    a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mm_wb |-> (state_reg == hcw_pkg::ST_MM_RUN && cnt_reg == CW'(YW - 1)))
        else $error("writeback before multiply finished");

endmodule
`default_nettype wire

FILE: hdl/hyper_cullen_woodall_factor_check_unit.sv
// Top level: checks whether p divides b^n*n^b+1 or b^n*n^b-1.
// b^n and n^b are formed by square-and-multiply, with a multiply for each set exponent bit;
//   each modular product is formed bit-serially, one multiplier bit per cycle.
// An even modulus or one below 3 skips the computation: residue zero, divides low.
// One item at a time; the next item is taken while the result waits for transfer.
// Reset (rst_n, async, active low) returns to idle with no result pending.
`default_nettype none
module hyper_cullen_woodall_factor_check_unit #(
    parameter int MODULUS_WIDTH  = hcw_pkg::MODULUS_WIDTH_DEF,
    parameter int EXPONENT_WIDTH = hcw_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hcw_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hcw_pkg::out_t      out_data
);

    hcw_pkg::cmd_t    cmd;
    hcw_pkg::status_t sts;

    hcw_controller #(
        .MW(MODULUS_WIDTH),
        .EW(EXPONENT_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hcw_datapath #(
        .MW(MODULUS_WIDTH),
        .EW(EXPONENT_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule
`default_nettype wire
